// ----- rtl/core/msarx_pkg.sv -----
`default_nettype none

package msarx_pkg;

   // field widths
   localparam int PULSE_W   = 12;
   localparam int GAIN_W    = 16;
   localparam int CMD_W     = 28;
   localparam int SPEED_W   = 32;
   localparam int DELAY_W   = 6;
   localparam int CSR_IDX_W = 3;

   // stream packing
   localparam int PULSE_LSB  = 0;
   localparam int INIT_LSB   = PULSE_LSB + PULSE_W;
   localparam int REQ_DATA_W = ((INIT_LSB + SPEED_W + 7) / 8) * 8;

   // fixed point: drive products carry 10 fewer fraction bits,
   // result rounded from 38 to 16 fraction bits
   localparam int DRIVE_SHIFT = 10;
   localparam int ROUND_SHIFT = 22;

   typedef logic [PULSE_W-1:0]        pulse_type;
   typedef logic [GAIN_W-1:0]         gain_type;
   typedef logic [CMD_W-1:0]          cmd_type;
   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic [DELAY_W-1:0]        delay_type;

   localparam pulse_type RST_PULSE_TOP      = PULSE_W'(2000);
   localparam pulse_type RST_SPIN_THRESHOLD = PULSE_W'(1100);
   localparam gain_type  RST_COMMAND_GAIN   = GAIN_W'(256);

   localparam speed_type SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam speed_type SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

   typedef enum logic [0:0] {
      ACT_ADVANCE = 1'b0,
      ACT_RESTART = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_TOP      = 3'd0,
      CSR_SPIN_THRESHOLD = 3'd1,
      CSR_COMMAND_GAIN   = 3'd2,
      CSR_SPEED_COEF_ONE = 3'd3,
      CSR_SPEED_COEF_TWO = 3'd4,
      CSR_DRIVE_COEF_ONE = 3'd5,
      CSR_DRIVE_COEF_TWO = 3'd6,
      CSR_DEAD_STEPS     = 3'd7
   } csr_index_type;

   // one transfer into the command ring
   typedef struct packed {
      logic    accept;
      logic    restart;
      cmd_type cmd;
   } ring_req_type;

endpackage

`default_nettype wire

// ----- rtl/core/msarx_ring.sv -----
`default_nettype none

module msarx_ring #(
   parameter int RING_DEPTH = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  msarx_pkg::ring_req_type ring_req,
   input  msarx_pkg::delay_type   dead_steps,
   output msarx_pkg::cmd_type     u_one,
   output msarx_pkg::cmd_type     u_two
);
   import msarx_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int LEN_W = ($clog2(RING_DEPTH + 1) > DELAY_W + 1) ?
                          $clog2(RING_DEPTH + 1) : DELAY_W + 1;
   localparam logic [LEN_W-1:0] MAX_DELAY = LEN_W'(RING_DEPTH - 3);
   localparam logic [LEN_W-1:0] GUARD     = LEN_W'(3);

   cmd_type                mem [RING_DEPTH];
   logic [LEN_W-1:0]       fill_ff, fill_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [LEN_W-1:0]       delay_ext, delay_cl, len, cur, cur_end, nxt1, nxt2_raw, nxt2;
   logic [PTR_W-1:0]       wr_addr, rd_one_addr, rd_two_addr;
   cmd_type                rd_one_ff, rd_two_ff;
   logic                   rd_one_ok_ff, rd_two_ok_ff;

   // active ring length and the three slots touched this step
   always_comb begin
      delay_ext = LEN_W'(dead_steps);
      delay_cl  = (delay_ext > MAX_DELAY) ? MAX_DELAY : delay_ext;
      len       = delay_cl + GUARD;
      // a pointer left beyond a shortened ring restarts at slot zero
      cur       = (LEN_W'(ptr_ff) < len) ? LEN_W'(ptr_ff) : '0;
      cur_end   = cur + LEN_W'(1);
      nxt1      = (cur_end == len) ? '0 : cur_end;
      nxt2_raw  = cur + LEN_W'(2);
      nxt2      = (nxt2_raw >= len) ? nxt2_raw - len : nxt2_raw;
      wr_addr     = PTR_W'(cur);
      rd_one_addr = PTR_W'(nxt2);
      rd_two_addr = PTR_W'(nxt1);
   end

   // written slots always form a run from slot zero; slots at or above
   // the fill mark read as zero
   always_comb begin
      fill_in = fill_ff;
      ptr_in  = ptr_ff;
      if (ring_req.accept) begin
         if (ring_req.restart) begin
            fill_in = '0;
            ptr_in  = '0;
         end else begin
            if (cur_end > fill_ff) begin
               fill_in = cur_end;
            end
            ptr_in = PTR_W'(nxt1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         ptr_ff  <= ptr_in;
      end
   end

   // read slots never equal the write slot, so read-before-write is safe
   always_ff @(posedge clock) begin
      if (ring_req.accept && !ring_req.restart) begin
         mem[wr_addr] <= ring_req.cmd;
      end
      if (ring_req.accept) begin
         rd_one_ff    <= mem[rd_one_addr];
         rd_two_ff    <= mem[rd_two_addr];
         rd_one_ok_ff <= (nxt2 < fill_ff);
         rd_two_ok_ff <= (nxt1 < fill_ff);
      end
   end

   assign u_one = rd_one_ok_ff ? rd_one_ff : '0;
   assign u_two = rd_two_ok_ff ? rd_two_ff : '0;

endmodule

`default_nettype wire

// ----- rtl/core/msarx_calc.sv -----
`default_nettype none

module msarx_calc #(
   parameter int COEF_WIDTH = 24
) (
   input  msarx_pkg::speed_type     speed_last,
   input  msarx_pkg::speed_type     speed_prev,
   input  wire signed [COEF_WIDTH-1:0] c_one,
   input  wire signed [COEF_WIDTH-1:0] c_two,
   input  wire signed [COEF_WIDTH-1:0] d_one,
   input  wire signed [COEF_WIDTH-1:0] d_two,
   input  msarx_pkg::cmd_type       u_one,
   input  msarx_pkg::cmd_type       u_two,
   output msarx_pkg::speed_type     speed
);
   import msarx_pkg::*;

   localparam int PROD_S_W = COEF_WIDTH + SPEED_W;
   localparam int PROD_D_W = COEF_WIDTH + CMD_W + 1;
   localparam int SUM_W    = COEF_WIDTH + SPEED_W + DRIVE_SHIFT;
   localparam int Q_W      = SUM_W - ROUND_SHIFT;
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(2 ** (ROUND_SHIFT - 1));

   logic signed [CMD_W:0]      u_one_s, u_two_s;
   logic signed [PROD_S_W-1:0] p_one, p_two;
   logic signed [PROD_D_W-1:0] p_three, p_four;
   logic signed [SUM_W-1:0]    drive_sum, total, rounded;
   logic signed [Q_W-1:0]      q;
   logic [Q_W-SPEED_W:0]       head;

   always_comb begin
      u_one_s   = $signed({1'b0, u_one});
      u_two_s   = $signed({1'b0, u_two});
      p_one     = c_one * speed_last;
      p_two     = c_two * speed_prev;
      p_three   = d_one * u_one_s;
      p_four    = d_two * u_two_s;
      drive_sum = SUM_W'(p_three) + SUM_W'(p_four);
      total     = SUM_W'(p_one) + SUM_W'(p_two) + (drive_sum <<< DRIVE_SHIFT);
      // round half up, then saturate to Q16.16
      rounded   = total + ROUND_BIAS;
      q         = $signed(rounded[SUM_W-1:ROUND_SHIFT]);
      head      = q[Q_W-1:SPEED_W-1];
      if ((&head) || !(|head)) begin
         speed = q[SPEED_W-1:0];
      end else if (q[Q_W-1]) begin
         speed = SPEED_MIN;
      end else begin
         speed = SPEED_MAX;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/motor_speed_arx_model_top.sv -----
// Motor speed model: second-order ARX recurrence with a transport delay.
//
// req_*  : one transfer per sample. tuser is the action (advance or restart),
//          tdata carries the pulse width and, for a restart, the initial speed.
// rsp_*  : one transfer per advance, the new Q16.16 speed (rounded, saturated).
//          A restart gives no transfer.
// csr_*  : register writes, always ready (unchecked): write only while the block is idle.
//
// Path: an accepted advance passes the compute stage, then the output register.
// Throughput: one item per cycle while rsp is not stalled. The figure is set
// by the speed loop: the four products, their sum and the saturation close
// combinationally through the speed registers; the command ring is read on accept.
// Stall: a held result keeps rsp_tvalid/rsp_tdata steady; one more item waits
// in the compute stage, after which req_tready drops until rsp_tready.
// Reset: registers take their reset values, speeds clear, and the command ring
// empties at once through a fill mark (no clearing pass); slots at or above
// it read as zero. A restart empties it the same way.
`default_nettype none

module motor_speed_arx_model_top #(
   parameter  int RING_DEPTH = 64,
   parameter  int COEF_WIDTH = 24,
   localparam int CSR_W = (COEF_WIDTH > msarx_pkg::GAIN_W) ? COEF_WIDTH : msarx_pkg::GAIN_W
) (
   input  wire                                clock,
   input  wire                                reset,
   // slave side
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [msarx_pkg::REQ_DATA_W-1:0]   req_tdata,  // pulse_width, initial_speed, pad
   input  wire                                req_tuser,  // action
   // master side
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [msarx_pkg::SPEED_W-1:0]      rsp_tdata,  // speed
   // register writes
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [msarx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_W-1:0]                   csr_wdata
);
   import msarx_pkg::*;

   // configuration
   pulse_type                pulse_top_ff, spin_threshold_ff;
   gain_type                 command_gain_ff;
   logic signed [COEF_WIDTH-1:0] speed_coef_one_ff, speed_coef_two_ff;
   logic signed [COEF_WIDTH-1:0] drive_coef_one_ff, drive_coef_two_ff;
   delay_type                dead_steps_ff;

   // pipeline
   logic         req_accept, s1_move;
   logic         s1_valid_ff, s1_valid_in, s1_restart_ff;
   speed_type    s1_init_ff;
   speed_type    speed_last_ff, speed_prev_ff, speed_new;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   speed_type    rsp_tdata_ff;
   action_type   action;
   pulse_type    pulse, pulse_cap, excess;
   cmd_type      cmd;
   cmd_type      u_one, u_two;
   ring_req_type ring_req;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_top_ff      <= RST_PULSE_TOP;
         spin_threshold_ff <= RST_SPIN_THRESHOLD;
         command_gain_ff   <= RST_COMMAND_GAIN;
         speed_coef_one_ff <= '0;
         speed_coef_two_ff <= '0;
         drive_coef_one_ff <= '0;
         drive_coef_two_ff <= '0;
         dead_steps_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PULSE_TOP:      pulse_top_ff      <= csr_wdata[PULSE_W-1:0];
            CSR_SPIN_THRESHOLD: spin_threshold_ff <= csr_wdata[PULSE_W-1:0];
            CSR_COMMAND_GAIN:   command_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_SPEED_COEF_ONE: speed_coef_one_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_SPEED_COEF_TWO: speed_coef_two_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_DRIVE_COEF_ONE: drive_coef_one_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_DRIVE_COEF_TWO: drive_coef_two_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_DEAD_STEPS:     dead_steps_ff     <= csr_wdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // drive command straight from the request: cap, threshold, gain
   always_comb begin
      action    = action_type'(req_tuser);
      pulse     = req_tdata[PULSE_LSB +: PULSE_W];
      pulse_cap = (pulse > pulse_top_ff) ? pulse_top_ff : pulse;
      excess    = pulse_cap - spin_threshold_ff;
      cmd       = (pulse_cap > spin_threshold_ff) ?
                  CMD_W'(excess) * CMD_W'(command_gain_ff) : '0;
   end

   // handshake: compute stage drains to the output register (a restart only reloads speeds)
   assign s1_move    = s1_valid_ff && (s1_restart_ff || !rsp_tvalid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   assign ring_req.accept  = req_accept;
   assign ring_req.restart = (action == ACT_RESTART);
   assign ring_req.cmd     = cmd;

   msarx_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .ring_req   (ring_req),
      .dead_steps (dead_steps_ff),
      .u_one      (u_one),
      .u_two      (u_two)
   );

   msarx_calc #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_calc (
      .speed_last (speed_last_ff),
      .speed_prev (speed_prev_ff),
      .c_one      (speed_coef_one_ff),
      .c_two      (speed_coef_two_ff),
      .d_one      (drive_coef_one_ff),
      .d_two      (drive_coef_two_ff),
      .u_one      (u_one),
      .u_two      (u_two),
      .speed      (speed_new)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_tvalid_in = rsp_tvalid_ff;
      if (s1_move && !s1_restart_ff) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         speed_last_ff <= '0;
         speed_prev_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (s1_move) begin
            if (s1_restart_ff) begin
               speed_last_ff <= s1_init_ff;
               speed_prev_ff <= s1_init_ff;
            end else begin
               speed_last_ff <= speed_new;
               speed_prev_ff <= speed_last_ff;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_restart_ff <= (action == ACT_RESTART);
         s1_init_ff    <= req_tdata[INIT_LSB +: SPEED_W];
      end
      if (s1_move && !s1_restart_ff) begin
         rsp_tdata_ff <= speed_new;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/msarx_checker.sv -----
`default_nettype none

module msarx_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata
);

   // nothing offered straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // an advance reaches the output when the receiver takes next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser) ##1 rsp_tready |=> rsp_tvalid)
      else $error("advance did not give a result in time");

   // the input side only stalls behind a held result
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

   // a held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("held result changed");

endmodule

bind motor_speed_arx_model_top msarx_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
   import msarx_pkg::*;

   // Block configuration as instantiated (defaults of the top level)
   localparam int RING_SLOTS    = 64;
   localparam int COEF_W        = 24;
   localparam int CSR_DATA_W    = (COEF_W > GAIN_W) ? COEF_W : GAIN_W;
   // Cycles with no transfer on any channel before the run is abandoned
   localparam int STALL_LIMIT   = 2000;
   // Quiet cycles after the last speed, so a trailing restart has landed
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 200;
   localparam int REPORT_MAX    = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // pulse_width, initial_speed, pad
   logic                  req_tuser  = 1'b0; // action

   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [SPEED_W-1:0]    rsp_tdata;         // speed

   logic                  csr_valid  = 1'b0;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   motor_speed_arx_model_top #(
      .RING_DEPTH (RING_SLOTS),
      .COEF_WIDTH (COEF_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Speed predictor: own copy of the registers and the model state
   // ------------------------------------------------------------------
   pulse_type                cfg_top, cfg_thr;
   gain_type                 cfg_gain;
   logic signed [COEF_W-1:0] cfg_c1, cfg_c2, cfg_d1, cfg_d2;
   delay_type                cfg_dead;

   speed_type   spd_last, spd_prev;
   cmd_type     cmd_ring [RING_SLOTS];
   int unsigned ring_pos;

   speed_type speed_expected [$];

   int mismatch_count  = 0;
   int results_checked = 0;
   int samples_sent    = 0;
   int restarts_sent   = 0;
   int csr_writes      = 0;

   // Idle odds in percent per cycle for each side, and a long receiver hold
   int req_idle_pct = 24;
   int rsp_idle_pct = 24;
   int hold_request = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   function automatic void model_restart(speed_type init);
      for (int i = 0; i < RING_SLOTS; i++) cmd_ring[i] = '0;
      ring_pos = 0;
      spd_last = init;
      spd_prev = init;
   endfunction

   function automatic void model_reset();
      cfg_top  = RST_PULSE_TOP;
      cfg_thr  = RST_SPIN_THRESHOLD;
      cfg_gain = RST_COMMAND_GAIN;
      cfg_c1   = '0;
      cfg_c2   = '0;
      cfg_d1   = '0;
      cfg_d2   = '0;
      cfg_dead = '0;
      model_restart('0);
   endfunction

   function automatic void model_write(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         CSR_PULSE_TOP:      cfg_top  = v[PULSE_W-1:0];
         CSR_SPIN_THRESHOLD: cfg_thr  = v[PULSE_W-1:0];
         CSR_COMMAND_GAIN:   cfg_gain = v[GAIN_W-1:0];
         CSR_SPEED_COEF_ONE: cfg_c1   = v[COEF_W-1:0];
         CSR_SPEED_COEF_TWO: cfg_c2   = v[COEF_W-1:0];
         CSR_DRIVE_COEF_ONE: cfg_d1   = v[COEF_W-1:0];
         CSR_DRIVE_COEF_TWO: cfg_d2   = v[COEF_W-1:0];
         CSR_DEAD_STEPS:     cfg_dead = v[DELAY_W-1:0];
         default: ;
      endcase
   endfunction

   // One advance: command into the ring, recurrence summed exactly at 38
   // fraction bits, rounded half up to Q16.16 and saturated.
   function automatic speed_type model_advance(pulse_type pulse);
      pulse_type          pw;
      cmd_type            cmd, u1, u2;
      int unsigned        d, n, p;
      logic signed [79:0] c1w, c2w, d1w, d2w, w1, w2, u1w, u2w, drive, acc, hi, lo;
      speed_type          next;
      pw  = (pulse > cfg_top) ? cfg_top : pulse;
      cmd = (pw > cfg_thr) ? cmd_type'(pw - cfg_thr) * cmd_type'(cfg_gain) : '0;
      d   = (cfg_dead > RING_SLOTS - 3) ? RING_SLOTS - 3 : cfg_dead;
      n   = d + 3;
      p   = (ring_pos < n) ? ring_pos : 0;
      cmd_ring[p] = cmd;
      u1  = cmd_ring[(p + 2) % n];
      u2  = cmd_ring[(p + 1) % n];
      c1w = cfg_c1;
      c2w = cfg_c2;
      d1w = cfg_d1;
      d2w = cfg_d2;
      w1  = spd_last;
      w2  = spd_prev;
      u1w = $signed({1'b0, u1});
      u2w = $signed({1'b0, u2});
      drive = d1w * u1w + d2w * u2w;
      acc = c1w * w1 + c2w * w2 + (drive <<< DRIVE_SHIFT) + (80'sd1 <<< (ROUND_SHIFT - 1));
      acc = acc >>> ROUND_SHIFT;
      hi  = SPEED_MAX;
      lo  = SPEED_MIN;
      if (acc > hi)      next = SPEED_MAX;
      else if (acc < lo) next = SPEED_MIN;
      else               next = acc[SPEED_W-1:0];
      spd_prev = spd_last;
      spd_last = next;
      ring_pos = (p + 1) % n;
      return next;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers: inputs change on the falling edge, handshakes are
   // sampled on the rising edge
   // ------------------------------------------------------------------
   task automatic send_sample(action_type act, pulse_type pulse, speed_type init);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = '0;
      req_tdata[PULSE_LSB +: PULSE_W] = pulse;
      req_tdata[INIT_LSB +: SPEED_W]  = init;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      if (act == ACT_RESTART) begin
         model_restart(init);
         restarts_sent++;
      end else begin
         speed_expected.push_back(model_advance(pulse));
      end
      // tvalid stays up; the next transfer or wait_idle decides
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      model_write(idx, value);
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_config(logic [11:0] top, logic [11:0] thr, logic [15:0] gain,
                              logic [23:0] c1, logic [23:0] c2,
                              logic [23:0] d1, logic [23:0] d2, logic [5:0] dead);
      write_reg(CSR_PULSE_TOP,      CSR_DATA_W'(top));
      write_reg(CSR_SPIN_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(CSR_COMMAND_GAIN,   CSR_DATA_W'(gain));
      write_reg(CSR_SPEED_COEF_ONE, CSR_DATA_W'(c1));
      write_reg(CSR_SPEED_COEF_TWO, CSR_DATA_W'(c2));
      write_reg(CSR_DRIVE_COEF_ONE, CSR_DATA_W'(d1));
      write_reg(CSR_DRIVE_COEF_TWO, CSR_DATA_W'(d2));
      write_reg(CSR_DEAD_STEPS,     CSR_DATA_W'(dead));
   endtask

   // Block idle: sender quiet, every speed back, a trailing restart settled
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (speed_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] signed_pick(int unsigned mag);
      int v;
      v = int'($urandom_range(mag));
      if ($urandom_range(1) != 0) v = -v;
      return 24'(v);
   endfunction

   task automatic report_mismatch(string what, logic [SPEED_W-1:0] got,
                                  logic [SPEED_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("MISMATCH %0t: %s: got %h expected %h", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random idling, plus a long hold requested by a test
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Speed checker: every transfer against the oldest prediction
   always @(posedge clock) begin : check_speed
      speed_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (speed_expected.size() == 0) begin
            report_mismatch("speed with no sample pending", rsp_tdata, '0);
         end else begin
            want = speed_expected.pop_front();
            results_checked++;
            if (rsp_tdata !== want) report_mismatch("speed", rsp_tdata, want);
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d speeds outstanding",
                     quiet_cycles, speed_expected.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Registers at reset values: zero coefficients keep the speed at zero
   task automatic test_reset_values();
      send_sample(ACT_ADVANCE, 12'd4095, '0);
      send_sample(ACT_RESTART, 12'd0, 32'hFFFF_FFFF);
      send_sample(ACT_ADVANCE, 12'd1101, '0);
      wait_idle();
   endtask

   // Full-scale registers and initial speeds: saturation both ways
   task automatic test_register_extremes();
      load_config(12'd4095, 12'd0, 16'hFFFF, 24'h7F_FFFF, 24'h80_0000,
                  24'h7F_FFFF, 24'h80_0000, 6'd0);
      send_sample(ACT_RESTART, 12'd0, 32'h7FFF_FFFF);
      send_sample(ACT_ADVANCE, 12'd4095, '0);
      send_sample(ACT_ADVANCE, 12'd4095, '0);
      send_sample(ACT_ADVANCE, 12'd0, '0);
      send_sample(ACT_RESTART, 12'hAAA, 32'h8000_0000);
      send_sample(ACT_ADVANCE, 12'd0, '0);
      send_sample(ACT_ADVANCE, 12'd4095, '0);
      wait_idle();
   endtask

   // Threshold equal to or above the top pulse: command is always zero
   task automatic test_threshold_at_top();
      load_config(12'd1000, 12'd1000, 16'd256, 24'h0, 24'h0,
                  24'h10_0000, 24'h10_0000, 6'd0);
      send_sample(ACT_ADVANCE, 12'd0, '0);
      send_sample(ACT_ADVANCE, 12'd999, '0);
      send_sample(ACT_ADVANCE, 12'd1000, '0);
      send_sample(ACT_ADVANCE, 12'd4095, '0);
      wait_idle();
      write_reg(CSR_SPIN_THRESHOLD, CSR_DATA_W'(4095));
      write_reg(CSR_PULSE_TOP, CSR_DATA_W'(0));
      send_sample(ACT_ADVANCE, 12'd4095, '0);
      send_sample(ACT_ADVANCE, 12'd2048, '0);
      wait_idle();
   endtask

   // Delay shortened mid-run (pointer beyond the new ring, stale contents
   // kept), then a delay above the largest the ring can hold
   task automatic test_delay_changes();
      load_config(12'd2000, 12'd1100, 16'd256, 24'h20_0000, 24'h0,
                  24'h01_0000, 24'h00_8000, 6'd7);
      for (int i = 0; i < 6; i++)
         send_sample(ACT_ADVANCE, pulse_type'(1200 + 100 * i), '0);
      wait_idle();
      write_reg(CSR_DEAD_STEPS, CSR_DATA_W'(1));
      for (int i = 0; i < 3; i++) send_sample(ACT_ADVANCE, 12'd1500, '0);
      wait_idle();
      write_reg(CSR_DEAD_STEPS, CSR_DATA_W'(63));
      send_sample(ACT_ADVANCE, 12'd3000, '0);
      send_sample(ACT_ADVANCE, 12'd1700, '0);
      wait_idle();
   endtask

   // Receiver holds off while the sender keeps offering: input must stall
   task automatic test_backpressure();
      load_config(12'd2500, 12'd900, 16'd300, 24'h30_0000, 24'hF0_0000,
                  24'h00_1000, 24'h00_0800, 6'd4);
      req_idle_pct = 0;
      hold_request = 60;
      for (int i = 0; i < 30; i++)
         send_sample(ACT_ADVANCE, pulse_type'($urandom_range(4095)), '0);
      req_idle_pct = 24;
      wait_idle();
   endtask

   // Random phases: each with its own register set, mostly advances
   task automatic test_random_phases();
      int unsigned style, c2mag, mag, roll;
      int          near;
      logic [23:0] c1, c2, d1, d2;
      pulse_type   pulse;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         // one phase runs flat out on both sides
         req_idle_pct = (phase == 3) ? 0 : 24;
         rsp_idle_pct = (phase == 3) ? 0 : 24;
         style = (phase < 2) ? 1 : (phase == PHASES - 1) ? 2 : $urandom_range(2);
         case (style)
            0: begin
               load_config(12'($urandom), 12'($urandom), 16'($urandom), 24'($urandom),
                           24'($urandom), 24'($urandom), 24'($urandom),
                           6'($urandom_range(63)));
            end
            1: begin
               // damped recurrence, small drive weights: speeds stay in range
               c2mag = $urandom_range(3355443);
               mag   = 4194304 - c2mag;
               c1    = signed_pick(mag - mag / 16);
               c2    = 24'(-int'(c2mag));
               d1    = signed_pick(4095);
               d2    = signed_pick(4095);
               load_config(12'($urandom_range(1500, 4095)), 12'($urandom_range(1500)),
                           16'($urandom_range(1023)), c1, c2, d1, d2,
                           ($urandom_range(3) == 0) ? 6'($urandom_range(50, 63))
                                                    : 6'($urandom_range(8)));
            end
            default: begin
               load_config($urandom_range(1) ? 12'd4095 : 12'd0,
                           $urandom_range(1) ? 12'd4095 : 12'd0,
                           $urandom_range(1) ? 16'hFFFF : 16'h0,
                           $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000,
                           $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000,
                           $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000,
                           $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000,
                           $urandom_range(1) ? 6'd63 : 6'd0);
            end
         endcase
         if ($urandom_range(1) != 0) send_sample(ACT_RESTART, 12'($urandom), $urandom);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
               send_sample(ACT_RESTART, 12'($urandom), $urandom);
            end else begin
               // pulses cluster round the threshold and the top now and then
               if (roll < 20)      near = int'(cfg_thr) + int'($urandom_range(6)) - 3;
               else if (roll < 30) near = int'(cfg_top) + int'($urandom_range(6)) - 3;
               else                near = int'($urandom_range(4095));
               if (near < 0)    near = 0;
               if (near > 4095) near = 4095;
               pulse = pulse_type'(near);
               send_sample(ACT_ADVANCE, pulse, $urandom);
            end
         end
      end
      req_idle_pct = 24;
      rsp_idle_pct = 24;
      wait_idle();
   endtask

   initial begin
      model_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_register_extremes();
      test_threshold_at_top();
      test_delay_changes();
      test_backpressure();
      test_random_phases();

      wait_idle();
      repeat (8) @(posedge clock);
      if (speed_expected.size() != 0)
         report_mismatch("speeds never delivered", '0, '0);

      $display("Run covered %0d samples (%0d restarts) and %0d register writes;",
               samples_sent, restarts_sent, csr_writes);
      $display("%0d speeds compared, %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
